// ===== rtl/sha256_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared payload types, the internal command type and the round constants.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // A word for the schedule buffer; a final word also starts padding.
  typedef struct packed {
    logic [31:0] word;
    logic        fin;       // the padding and length words follow this one
    logic        add_pad;   // a separate 0x80 word follows (full last word)
    logic [5:0]  nbits_add; // bits added to the length by this word
  } cmd_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [3:0]  LEN_HI_SLOT = 4'd14;

endpackage
`default_nettype wire

// ===== rtl/sha256_hash_engine_top.sv =====
`default_nettype none
// A block of 16 words is loaded into the buffer, then compressed round by round;
// the last item adds one or two padded blocks, then eight digest transfers.
// One round unit does all rounds; while it runs, the back end takes no word.
// Reset: synchronous rst restores the initial hash values and empties the
// queue; the back end also restores the initial hash values after each digest.
// ----------------------------------------------------------------------------
// SHA-256 hash engine top level
// Front end queues masked input words; back end compresses and emits digest.
// ----------------------------------------------------------------------------
module sha256_hash_engine_top #(
  parameter int unsigned QUEUE_LOG2 = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire sha256_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output sha256_pkg::out_item_t      out_data
);

  // Command queue between front and back.
  logic             cmd_valid, cmd_ready;
  sha256_pkg::cmd_t cmd;

  sha256_front #(.DEPTH_LOG2(QUEUE_LOG2)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd_ready, .cmd
  );

  sha256_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

// ===== rtl/sha256_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input transfers, masks and pads the word, queues a command.
// ----------------------------------------------------------------------------
module sha256_front #(
  parameter int unsigned DEPTH_LOG2 = 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sha256_pkg::in_item_t in_data,
  output logic                     cmd_valid,
  input  wire logic                cmd_ready,
  output sha256_pkg::cmd_t         cmd
);

  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

  sha256_pkg::cmd_t        q [DEPTH];
  logic [DEPTH_LOG2-1:0]   wr_ptr, rd_ptr;
  logic [DEPTH_LOG2:0]     count;
  sha256_pkg::cmd_t        cmd_new;
  logic [2:0]              nb;
  logic [31:0]             keep;
  logic                    push, pop;

  always_comb begin
    nb = in_data.byte_count;
    if (!in_data.last_item || nb > 3'd4) nb = 3'd4;
    unique case (nb)
      3'd0:    keep = 32'h00000000;
      3'd1:    keep = 32'hff000000;
      3'd2:    keep = 32'hffff0000;
      3'd3:    keep = 32'hffffff00;
      default: keep = 32'hffffffff;
    endcase
    cmd_new.word = in_data.data_word & keep;
    // Short final word carries its own 0x80 marker.
    if (in_data.last_item && nb != 3'd4)
      cmd_new.word = cmd_new.word | (sha256_pkg::PAD_WORD >> {nb, 3'b000});
    cmd_new.fin       = in_data.last_item;
    cmd_new.add_pad   = in_data.last_item && nb == 3'd4;
    cmd_new.nbits_add = {nb, 3'b000};
  end

  assign in_ready  = count != DEPTH[DEPTH_LOG2:0];
  assign cmd_valid = count != '0;
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cmd_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{DEPTH_LOG2{1'b0}}, push} - {{DEPTH_LOG2{1'b0}}, pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH[DEPTH_LOG2:0]) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    count == DEPTH[DEPTH_LOG2:0] |-> !push) else $error("push into full queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("count step");

endmodule
`default_nettype wire

// ===== rtl/sha256_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 back end
// Fills the block buffer, runs one round per cycle, pads, emits the digest.
// ----------------------------------------------------------------------------
module sha256_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire sha256_pkg::cmd_t     cmd,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sha256_pkg::out_item_t     out_data
);

  typedef enum logic [2:0] {
    S_LOAD, S_PAD, S_ZERO, S_LEN_HI, S_LEN_LO, S_ROUND, S_OUT
  } state_t;

  state_t      state;
  state_t      ret_state;
  logic [31:0] w [16];
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [3:0]  fill_count;
  logic [63:0] bit_length;
  logic [5:0]  round_count;
  logic [2:0]  out_idx;

  logic [31:0] wt, x2, x15, s0, s1, sig1, sig0, ch, maj, t1, t2, w_new;
  logic        slot_word;
  logic [31:0] slot_data;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    x2    = w[round_count[3:0] - 4'd2];
    x15   = w[round_count[3:0] - 4'd15];
    s1    = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
    s0    = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
    w_new = s1 + w[round_count[3:0] - 4'd7] + s0 + w[round_count[3:0]];
    wt    = (round_count < 6'd16) ? w[round_count[3:0]] : w_new;
    sig1  = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + sig1 + ch + sha256_pkg::ROUND_K[round_count] + wt;
    sig0  = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = sig0 + maj;
  end

  // One buffer word per cycle in the fill states; in S_LOAD only while cmd_valid.
  always_comb begin
    slot_word = 1'b0;
    slot_data = '0;
    unique case (state)
      S_LOAD:   begin slot_word = cmd_valid; slot_data = cmd.word; end
      S_PAD:    begin slot_word = 1'b1; slot_data = sha256_pkg::PAD_WORD; end
      S_ZERO:   begin slot_word = 1'b1; slot_data = '0; end
      S_LEN_HI: begin slot_word = 1'b1; slot_data = bit_length[63:32]; end
      S_LEN_LO: begin slot_word = 1'b1; slot_data = bit_length[31:0]; end
      default:  begin slot_word = 1'b0; slot_data = '0; end
    endcase
  end

  assign cmd_ready = state == S_LOAD;
  assign out_valid = state == S_OUT;
  assign out_data.digest_word = h[out_idx];
  assign out_data.word_index  = out_idx;
  assign out_data.last_word   = out_idx == 3'd7;

  // Next fill state once a word lands in slot fill_count.
  function automatic state_t after_word(input state_t cur, input logic [3:0] fc,
                                        input logic add_pad);
    state_t nxt;
    priority if (cur == S_LOAD && add_pad) nxt = S_PAD;
    else if (cur == S_LEN_HI) nxt = S_LEN_LO;
    else if (cur == S_LEN_LO) nxt = S_OUT;
    else if (fc == 4'd13) nxt = S_LEN_HI;
    else nxt = S_ZERO;
    return nxt;
  endfunction

  always_ff @(posedge clk) begin
    if (slot_word) w[fill_count] <= slot_data;
    else if (state == S_ROUND && round_count >= 6'd16) w[round_count[3:0]] <= w_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      ret_state   <= S_LOAD;
      fill_count  <= '0;
      bit_length  <= '0;
      round_count <= '0;
      out_idx     <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::INIT_H[i];
    end else begin
      unique case (state)
        S_LOAD, S_PAD, S_ZERO, S_LEN_HI, S_LEN_LO: begin
          if (slot_word) begin
            state_t nxt;
            logic   fin;
            fin = (state == S_LOAD) ? cmd.fin : 1'b1;
            if (state == S_LOAD) bit_length <= bit_length + 64'(cmd.nbits_add);
            nxt = fin ? after_word(state, fill_count, cmd.add_pad) : S_LOAD;
            if (state == S_LOAD && cmd.fin && cmd.add_pad) nxt = S_PAD;
            fill_count <= fill_count + 4'd1;
            if (fill_count == 4'd15) begin
              for (int i = 0; i < 8; i++) v[i] <= h[i];
              round_count <= '0;
              ret_state   <= (nxt == S_OUT) ? S_OUT : (fin ? ((nxt == S_LEN_HI ||
                             nxt == S_PAD) ? nxt : S_ZERO) : S_LOAD);
              state       <= S_ROUND;
            end else begin
              // Length words go in slots 14 and 15 only.
              if (fin && fill_count == 4'd13 && state != S_LOAD) state <= S_LEN_HI;
              else if (fin && state == S_LOAD && !cmd.add_pad && fill_count == 4'd13)
                state <= S_LEN_HI;
              else if (fin && nxt == S_ZERO && fill_count + 4'd1 == sha256_pkg::LEN_HI_SLOT)
                state <= S_LEN_HI;
              else state <= nxt;
            end
          end
        end
        S_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          if (round_count == 6'd63) begin
            round_count <= '0;
            state       <= ret_state;
            h[0] <= h[0] + t1 + t2;
            h[1] <= h[1] + v[0]; h[2] <= h[2] + v[1]; h[3] <= h[3] + v[2];
            h[4] <= h[4] + v[3] + t1;
            h[5] <= h[5] + v[4]; h[6] <= h[6] + v[5]; h[7] <= h[7] + v[6];
          end else begin
            round_count <= round_count + 6'd1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state      <= S_LOAD;
              fill_count <= '0;
              bit_length <= '0;
              for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::INIT_H[i];
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> state == S_LOAD) else $error("ready outside load");
  a_round_wrap: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND && round_count == 6'd63 |=> state != S_ROUND)
    else $error("round count overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_idx))
    else $error("digest word dropped");

endmodule
`default_nettype wire
